// ===== hw/rtl/mse_pkg.sv =====
// Shared types and codes for the MIPS subset execute block.
package mse_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SW  = 3'd1;
	localparam logic [2:0] OP_LW  = 3'd2;
	localparam logic [2:0] OP_LUI = 3'd3;
	localparam logic [2:0] OP_ORI = 3'd4;
	localparam logic [2:0] OP_NOP = 3'd5;

	localparam int MEM_ADDR_W = 10;

	typedef enum logic [2:0] {
		CLS_NOP,
		CLS_ADD,
		CLS_STORE,
		CLS_LOAD,
		CLS_LUI,
		CLS_ORI
	} mse_cls_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [4:0]  src_reg;
		logic [4:0]  tgt_reg;
		logic [4:0]  dst_reg;
		logic [15:0] immediate;
	} mse_instr_t;

	typedef struct packed {
		logic                  reg_write_valid;
		logic [4:0]            reg_write_index;
		logic [31:0]           reg_write_value;
		logic                  mem_write_valid;
		logic [MEM_ADDR_W-1:0] mem_word_address;
		logic [31:0]           mem_write_value;
		logic [31:0]           next_count;
	} mse_result_t;

	typedef struct packed {
		mse_cls_t    cls;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic        wr;
		logic [4:0]  wr_idx;
		logic [15:0] imm;
	} mse_uop_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} mse_ctl_t;

endpackage

// ===== hw/rtl/mips_subset_execute.sv =====
// Path from an accepted instruction beat to its result beat: queue, s1 to s5, output register.
// Throughput: one instruction per cycle while result_stall is low; forwarding covers all
// ALU results, a load holds a dependent instruction in operand read while the load is in
// the address reduction stages s2 to s4. Reset: registers and counter clear at once; the
// data memory is cleared by a pass over all DATA_WORDS words after reset, during which
// instr_stall is high. Top level of the MIPS subset execute block.
module mips_subset_execute import mse_pkg::*; #(
	parameter int DATA_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  mse_instr_t  instr,
	output logic        result_valid,
	input  logic        result_stall,
	output mse_result_t result
);

	logic     head_valid;
	mse_uop_t head;
	mse_ctl_t ctl;

	mse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr       (instr),
		.head_valid  (head_valid),
		.head        (head),
		.ctl         (ctl)
	);

	mse_back #(
		.DATA_WORDS (DATA_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.ctl          (ctl),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== hw/rtl/mse_front.sv =====
// Front end: accepts instruction beats, classifies them and queues them for execution.
module mse_front import mse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       instr_valid,
	output logic       instr_stall,
	input  mse_instr_t instr,
	output logic       head_valid,
	output mse_uop_t   head,
	input  mse_ctl_t   ctl
);

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);

	mse_uop_t       q_mem [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   cnt_q;
	logic           push;
	logic           pop;
	mse_uop_t       dec;

	always_comb begin
		dec.rs     = instr.src_reg;
		dec.rt     = instr.tgt_reg;
		dec.imm    = instr.immediate;
		dec.wr_idx = instr.tgt_reg;
		case (instr.operation)
			OP_ADD: begin
				dec.cls    = CLS_ADD;
				dec.wr_idx = instr.dst_reg;
			end
			OP_SW:  dec.cls = CLS_STORE;
			OP_LW:  dec.cls = CLS_LOAD;
			OP_LUI: dec.cls = CLS_LUI;
			OP_ORI: dec.cls = CLS_ORI;
			OP_NOP: dec.cls = CLS_NOP;
			default: dec.cls = CLS_NOP;
		endcase
		dec.wr = (dec.cls == CLS_ADD || dec.cls == CLS_LOAD || dec.cls == CLS_LUI ||
			dec.cls == CLS_ORI) && (dec.wr_idx != 5'd0);
	end

	assign instr_stall = (cnt_q == (QPW+1)'(QDEPTH)) || ctl.busy;
	assign push        = instr_valid && !instr_stall;
	assign head_valid  = (cnt_q != '0);
	assign head        = q_mem[rd_ptr_q];
	assign pop         = ctl.pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/mse_back.sv =====
// Back end: operand read with forwarding, address reduction, data memory and writeback.
module mse_back import mse_pkg::*; #(
	parameter int DATA_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  mse_uop_t    head,
	output mse_ctl_t    ctl,
	output logic        result_valid,
	input  logic        result_stall,
	output mse_result_t result
);

	localparam int AW = $clog2(DATA_WORDS);
	localparam int RW = 33 - AW;
	localparam logic [63:0]   RECIP64 = (64'd1 << 32) / 64'(DATA_WORDS);
	localparam logic [RW-1:0] RECIP   = RW'(RECIP64);
	localparam logic [AW:0]   NWORDS  = (AW+1)'(DATA_WORDS);
	localparam logic [AW-1:0] LAST    = AW'(DATA_WORDS - 1);

	typedef struct packed {
		mse_cls_t    cls;
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] val;
		logic [31:0] sum;
		logic [31:0] st;
	} ex_t;

	typedef struct packed {
		logic        hit;
		logic [4:0]  idx;
		logic        pend;
		logic [31:0] val;
	} fwd_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] val;
	} wb_t;

	typedef struct packed {
		logic        pend;
		logic [31:0] val;
	} opnd_t;

	function automatic opnd_t pick(logic [4:0] idx, fwd_t [3:0] fw, wb_t wb,
		logic [31:0] rfd);
		opnd_t o;
		o.pend = 1'b0;
		o.val  = rfd;
		if (wb.en && wb.idx == idx) begin
			o.val = wb.val;
		end
		for (int i = 3; i >= 0; i--) begin
			if (fw[i].hit && fw[i].idx == idx) begin
				o.pend = fw[i].pend;
				o.val  = fw[i].val;
			end
		end
		return o;
	endfunction

	logic [31:0]    rf_mem [32];
	logic [31:0]    rf_vld_q;
	logic [31:0]    dmem [DATA_WORDS];
	logic           clr_busy_q;
	logic [AW-1:0]  clr_idx_q;
	logic [31:0]    cnt_q;
	wb_t            wb_q;

	logic           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	mse_uop_t       uop_s1;
	logic [31:0]    rs_data_s1, rt_data_s1;
	ex_t            ex_s2, ex_s3, ex_s4, ex_s5;
	logic [RW-1:0]  q_s3;
	logic [31:0]    p2_s4;
	logic [AW-1:0]  addr_s5;
	logic [31:0]    mem_rd_s5;

	logic           out_vld_q;
	mse_result_t    out_q;

	logic           adv;
	logic           hazard;
	logic           s1_take;
	logic [4:0]     ra, rb;
	fwd_t [3:0]     fw;
	opnd_t          opa, opb;
	logic           use_rs, use_rt;
	ex_t            ex1;
	logic [31:0]    sext;
	logic [31+RW:0] p1_w;
	logic [31:0]    p2_w;
	logic [31:0]    diff_w;
	logic [AW:0]    r_w;
	logic [AW-1:0]  addr_w;
	logic [31:0]    val5;
	logic           wb_en;
	logic           mem_op5;
	mse_result_t    res;

	assign adv     = !out_vld_q || !result_stall;
	assign s1_take = adv && (!vld_s1 || !hazard);
	assign ra      = s1_take ? head.rs : uop_s1.rs;
	assign rb      = s1_take ? head.rt : uop_s1.rt;

	assign ctl.pop  = s1_take;
	assign ctl.busy = clr_busy_q;

	assign val5 = (ex_s5.cls == CLS_LOAD) ? mem_rd_s5 : ex_s5.val;

	always_comb begin
		fw[0] = '{hit: vld_s2 && ex_s2.wr, idx: ex_s2.idx,
			pend: ex_s2.cls == CLS_LOAD, val: ex_s2.val};
		fw[1] = '{hit: vld_s3 && ex_s3.wr, idx: ex_s3.idx,
			pend: ex_s3.cls == CLS_LOAD, val: ex_s3.val};
		fw[2] = '{hit: vld_s4 && ex_s4.wr, idx: ex_s4.idx,
			pend: ex_s4.cls == CLS_LOAD, val: ex_s4.val};
		fw[3] = '{hit: vld_s5 && ex_s5.wr, idx: ex_s5.idx, pend: 1'b0, val: val5};
	end

	assign opa    = pick(uop_s1.rs, fw, wb_q, rs_data_s1);
	assign opb    = pick(uop_s1.rt, fw, wb_q, rt_data_s1);
	assign use_rs = (uop_s1.cls == CLS_ADD) || (uop_s1.cls == CLS_STORE) ||
		(uop_s1.cls == CLS_LOAD) || (uop_s1.cls == CLS_ORI);
	assign use_rt = (uop_s1.cls == CLS_ADD) || (uop_s1.cls == CLS_STORE);
	assign hazard = vld_s1 && ((use_rs && opa.pend) || (use_rt && opb.pend));
	assign sext   = {{16{uop_s1.imm[15]}}, uop_s1.imm};

	always_comb begin
		ex1.cls = uop_s1.cls;
		ex1.wr  = uop_s1.wr;
		ex1.idx = uop_s1.wr_idx;
		ex1.sum = opa.val + sext;
		ex1.st  = opb.val;
		case (uop_s1.cls)
			CLS_ADD: ex1.val = opa.val + opb.val;
			CLS_LUI: ex1.val = {uop_s1.imm, 16'h0000};
			CLS_ORI: ex1.val = opa.val | {16'h0000, uop_s1.imm};
			default: ex1.val = '0;
		endcase
	end

	// address modulo DATA_WORDS: reciprocal estimate, back-multiply, one correction
	assign p1_w   = (32+RW)'(ex_s2.sum) * (32+RW)'(RECIP);
	assign p2_w   = 32'(q_s3) * 32'(DATA_WORDS);
	assign diff_w = ex_s4.sum - p2_s4;
	assign r_w    = diff_w[AW:0];
	assign addr_w = (r_w >= NWORDS) ? AW'(r_w - NWORDS) : r_w[AW-1:0];

	assign wb_en   = adv && vld_s5 && ex_s5.wr;
	assign mem_op5 = (ex_s5.cls == CLS_LOAD) || (ex_s5.cls == CLS_STORE);

	always_comb begin
		res.reg_write_valid  = ex_s5.wr;
		res.reg_write_index  = ex_s5.wr ? ex_s5.idx : '0;
		res.reg_write_value  = ex_s5.wr ? val5 : '0;
		res.mem_write_valid  = (ex_s5.cls == CLS_STORE);
		res.mem_word_address = mem_op5 ? MEM_ADDR_W'(addr_s5) : '0;
		res.mem_write_value  = (ex_s5.cls == CLS_STORE) ? ex_s5.st : '0;
		res.next_count       = cnt_q + 32'd1;
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_ff @(posedge clk) begin
		rs_data_s1 <= rf_vld_q[ra] ? rf_mem[ra] : '0;
		rt_data_s1 <= rf_vld_q[rb] ? rf_mem[rb] : '0;
		if (wb_en) begin
			rf_mem[ex_s5.idx] <= val5;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			dmem[clr_idx_q] <= '0;
		end else if (adv && vld_s4 && ex_s4.cls == CLS_STORE) begin
			dmem[addr_w] <= ex_s4.st;
		end
		if (adv) begin
			mem_rd_s5 <= dmem[addr_w];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			uop_s1 <= head;
		end
		if (adv) begin
			ex_s2   <= ex1;
			ex_s3   <= ex_s2;
			q_s3    <= p1_w[32 +: RW];
			ex_s4   <= ex_s3;
			p2_s4   <= p2_w;
			ex_s5   <= ex_s4;
			addr_s5 <= addr_w;
			if (vld_s5) begin
				out_q <= res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			out_vld_q  <= 1'b0;
			cnt_q      <= '0;
			rf_vld_q   <= '0;
			wb_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (s1_take) begin
				vld_s1 <= head_valid;
			end
			if (adv) begin
				vld_s2    <= vld_s1 && !hazard;
				vld_s3    <= vld_s2;
				vld_s4    <= vld_s3;
				vld_s5    <= vld_s4;
				out_vld_q <= vld_s5;
				if (vld_s5) begin
					cnt_q <= cnt_q + 32'd1;
				end
			end
			wb_q <= '{en: wb_en, idx: ex_s5.idx, val: val5};
			if (wb_en) begin
				rf_vld_q[ex_s5.idx] <= 1'b1;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5 || out_vld_q))
		else $error("item in flight during memory clear");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |-> ex_s5.idx != 5'd0)
		else $error("write to register zero");

	a_hazard_load: assert property (@(posedge clk) disable iff (!arst_n)
		hazard |-> ((vld_s2 && ex_s2.cls == CLS_LOAD) || (vld_s3 && ex_s3.cls == CLS_LOAD) ||
			(vld_s4 && ex_s4.cls == CLS_LOAD)))
		else $error("interlock without a load in flight");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && mem_op5) |-> ({1'b0, addr_s5} < NWORDS))
		else $error("word address beyond memory depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s5) |=> (cnt_q == $past(cnt_q) + 32'd1))
		else $error("instruction count did not advance by one");

endmodule

// ===== bench/mips_subset_execute_tb.sv =====
// Self-checking testbench for mips_subset_execute: directed table, then random instruction streams.
module mips_subset_execute_tb;
	import mse_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_WORDS     = 1024;
	localparam int DIR_ROWS       = 25;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int HOLD_CYCLES    = 250;
	localparam int HOLD_AFTER     = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 8000;

	// unused operation codes, executed as nop
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_HOLD} stall_mode_t;

	typedef struct packed {
		mse_instr_t  ins;
		logic        typed;
		mse_result_t want;
	} dir_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        instr_valid  = 1'b0;
	logic        instr_stall;
	mse_instr_t  instr        = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	mse_result_t result;

	logic [31:0] gpr [32];
	logic [31:0] dmem [DATA_WORDS];
	bit          dmem_written [DATA_WORDS];
	logic [31:0] icount;

	mse_result_t expected_q [$];
	int          accepted_n   = 0;
	int          checked_n    = 0;
	int          mismatches   = 0;
	int          idle_cycles  = 0;
	int          burst_left   = 0;
	int          ops_seen [8];
	int          lw_hits      = 0;
	int          r0_drops     = 0;
	bit          hold_off     = 1'b0;
	bit          hold_done    = 1'b0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{'{OP_LUI,   5'd0,  5'd1,  5'd0,  16'hFFFF}, 1'b1,
			'{1'b1, 5'd1,  32'hFFFF0000, 1'b0, 10'd0,    32'h0,        32'd1}},
		'{'{OP_ORI,   5'd0,  5'd2,  5'd0,  16'hFFFF}, 1'b1,
			'{1'b1, 5'd2,  32'h0000FFFF, 1'b0, 10'd0,    32'h0,        32'd2}},
		'{'{OP_ADD,   5'd1,  5'd2,  5'd3,  16'h0000}, 1'b1,
			'{1'b1, 5'd3,  32'hFFFFFFFF, 1'b0, 10'd0,    32'h0,        32'd3}},
		'{'{OP_ADD,   5'd3,  5'd3,  5'd4,  16'h0000}, 1'b1,
			'{1'b1, 5'd4,  32'hFFFFFFFE, 1'b0, 10'd0,    32'h0,        32'd4}},
		'{'{OP_LUI,   5'd0,  5'd0,  5'd0,  16'h1234}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b0, 10'd0,    32'h0,        32'd5}},
		'{'{OP_SW,    5'd0,  5'd3,  5'd0,  16'h0000}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b1, 10'd0,    32'hFFFFFFFF, 32'd6}},
		'{'{OP_LW,    5'd0,  5'd5,  5'd0,  16'h0000}, 1'b1,
			'{1'b1, 5'd5,  32'hFFFFFFFF, 1'b0, 10'd0,    32'h0,        32'd7}},
		'{'{OP_SW,    5'd0,  5'd2,  5'd0,  16'hFFFF}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b1, 10'd1023, 32'h0000FFFF, 32'd8}},
		'{'{OP_LW,    5'd0,  5'd6,  5'd0,  16'h03FF}, 1'b1,
			'{1'b1, 5'd6,  32'h0000FFFF, 1'b0, 10'd1023, 32'h0,        32'd9}},
		'{'{OP_LW,    5'd0,  5'd0,  5'd0,  16'h8000}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b0, 10'd0,    32'h0,        32'd10}},
		'{'{OP_NOP,   5'd31, 5'd31, 5'd31, 16'hFFFF}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b0, 10'd0,    32'h0,        32'd11}},
		'{'{OP_RSVD6, 5'd31, 5'd31, 5'd31, 16'hFFFF}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b0, 10'd0,    32'h0,        32'd12}},
		'{'{OP_RSVD7, 5'd31, 5'd31, 5'd31, 16'hFFFF}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b0, 10'd0,    32'h0,        32'd13}},
		'{'{OP_ADD,   5'd1,  5'd2,  5'd0,  16'h0000}, 1'b1,
			'{1'b0, 5'd0,  32'h0,        1'b0, 10'd0,    32'h0,        32'd14}},
		'{'{OP_ORI,   5'd1,  5'd7,  5'd0,  16'h00FF}, 1'b1,
			'{1'b1, 5'd7,  32'hFFFF00FF, 1'b0, 10'd0,    32'h0,        32'd15}},
		'{'{OP_ADD,   5'd3,  5'd2,  5'd31, 16'h0000}, 1'b1,
			'{1'b1, 5'd31, 32'h0000FFFE, 1'b0, 10'd0,    32'h0,        32'd16}},
		'{'{OP_SW,    5'd31, 5'd31, 5'd0,  16'h7FFF}, 1'b0, '0},
		'{'{OP_LW,    5'd31, 5'd8,  5'd0,  16'h7FFF}, 1'b0, '0},
		'{'{OP_ADD,   5'd8,  5'd8,  5'd9,  16'h0000}, 1'b0, '0},
		'{'{OP_SW,    5'd0,  5'd9,  5'd0,  16'h0010}, 1'b0, '0},
		'{'{OP_LW,    5'd0,  5'd10, 5'd0,  16'h0010}, 1'b0, '0},
		'{'{OP_ORI,   5'd10, 5'd10, 5'd0,  16'h8000}, 1'b0, '0},
		'{'{OP_LW,    5'd1,  5'd11, 5'd0,  16'h8000}, 1'b0, '0},
		'{'{OP_LUI,   5'd0,  5'd31, 5'd0,  16'h0000}, 1'b0, '0},
		'{'{OP_ADD,   5'd31, 5'd0,  5'd12, 16'h0000}, 1'b0, '0}
	};

	mips_subset_execute #(
		.DATA_WORDS(DATA_WORDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr(instr),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		for (int i = 0; i < DATA_WORDS; i++) begin
			dmem[i] = '0;
			dmem_written[i] = 1'b0;
		end
		for (int i = 0; i < 8; i++) ops_seen[i] = 0;
		icount = '0;
	end

	// executes one instruction on the shadow state, returns the result beat it should produce
	function automatic mse_result_t execute_instr(mse_instr_t ins);
		mse_result_t r;
		logic [31:0] ea;
		int unsigned widx;
		r = '0;
		ea = gpr[ins.src_reg] + {{16{ins.immediate[15]}}, ins.immediate};
		widx = ea % DATA_WORDS;
		case (ins.operation)
			OP_ADD: begin
				r.reg_write_valid = 1'b1;
				r.reg_write_index = ins.dst_reg;
				r.reg_write_value = gpr[ins.src_reg] + gpr[ins.tgt_reg];
			end
			OP_SW: begin
				r.mem_write_valid  = 1'b1;
				r.mem_word_address = widx[MEM_ADDR_W-1:0];
				r.mem_write_value  = gpr[ins.tgt_reg];
				dmem[widx] = gpr[ins.tgt_reg];
				dmem_written[widx] = 1'b1;
			end
			OP_LW: begin
				r.mem_word_address = widx[MEM_ADDR_W-1:0];
				r.reg_write_valid  = 1'b1;
				r.reg_write_index  = ins.tgt_reg;
				r.reg_write_value  = dmem[widx];
				if (dmem_written[widx]) lw_hits++;
			end
			OP_LUI: begin
				r.reg_write_valid = 1'b1;
				r.reg_write_index = ins.tgt_reg;
				r.reg_write_value = {ins.immediate, 16'h0000};
			end
			OP_ORI: begin
				r.reg_write_valid = 1'b1;
				r.reg_write_index = ins.tgt_reg;
				r.reg_write_value = gpr[ins.src_reg] | {16'h0000, ins.immediate};
			end
			default: ;
		endcase
		if (r.reg_write_valid && r.reg_write_index == 5'd0) begin
			r.reg_write_valid = 1'b0;
			r.reg_write_value = '0;
			r0_drops++;
		end
		if (r.reg_write_valid) gpr[r.reg_write_index] = r.reg_write_value;
		icount = icount + 32'd1;
		r.next_count = icount;
		return r;
	endfunction

	// mostly dependent streams over a few registers and a small address window, some noise
	function automatic mse_instr_t rand_instr();
		mse_instr_t ins;
		int pick;
		ins.operation = 3'($urandom_range(0, 7));
		ins.src_reg   = 5'($urandom_range(0, 31));
		ins.tgt_reg   = 5'($urandom_range(0, 31));
		ins.dst_reg   = 5'($urandom_range(0, 31));
		ins.immediate = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 3) == 0) return ins;
		pick = $urandom_range(0, 99);
		ins.operation = pick < 22 ? OP_ADD : pick < 42 ? OP_SW : pick < 64 ? OP_LW :
			pick < 74 ? OP_LUI : pick < 88 ? OP_ORI : OP_NOP;
		ins.src_reg = 5'($urandom_range(0, 7));
		ins.tgt_reg = 5'($urandom_range(0, 7));
		ins.dst_reg = 5'($urandom_range(0, 7));
		if (ins.operation inside {OP_SW, OP_LW, OP_ORI} && $urandom_range(0, 1) == 1) begin
			ins.src_reg   = 5'd0;
			ins.immediate = 16'($urandom_range(0, 63)) - 16'd32;
		end
		return ins;
	endfunction

	task automatic send_instr(mse_instr_t ins, logic typed, mse_result_t want);
		mse_result_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (!hold_off && $urandom_range(0, 2) != 0) begin
				instr_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		instr_valid <= 1'b1;
		instr       <= ins;
		do @(posedge clk); while (instr_stall);
		accepted_n++;
		ops_seen[ins.operation]++;
		pred = execute_instr(ins);
		expected_q.push_back(typed ? want : pred);
	endtask

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch at result beat %0d: %s got %h expected %h",
			checked_n, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		mse_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				flag_mismatch("beat with nothing outstanding", '0, '0);
			end else begin
				want = expected_q.pop_front();
				if (result.reg_write_valid != want.reg_write_valid)
					flag_mismatch("reg_write_valid", 32'(result.reg_write_valid),
						32'(want.reg_write_valid));
				if (result.reg_write_index != want.reg_write_index)
					flag_mismatch("reg_write_index", 32'(result.reg_write_index),
						32'(want.reg_write_index));
				if (result.reg_write_value != want.reg_write_value)
					flag_mismatch("reg_write_value", result.reg_write_value, want.reg_write_value);
				if (result.mem_write_valid != want.mem_write_valid)
					flag_mismatch("mem_write_valid", 32'(result.mem_write_valid),
						32'(want.mem_write_valid));
				if (result.mem_word_address != want.mem_word_address)
					flag_mismatch("mem_word_address", 32'(result.mem_word_address),
						32'(want.mem_word_address));
				if (result.mem_write_value != want.mem_write_value)
					flag_mismatch("mem_write_value", result.mem_write_value, want.mem_write_value);
				if (result.next_count != want.next_count)
					flag_mismatch("next_count", result.next_count, want.next_count);
			end
			checked_n++;
		end
	end

	// output back-pressure; one long hold-off once the stream is well under way
	initial begin : result_backpressure
		stall_mode_t mode;
		int seg;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			seg  = $urandom_range(10, 60);
			if (!hold_done && accepted_n >= HOLD_AFTER) begin
				mode     = STALL_HOLD;
				seg      = HOLD_CYCLES;
				hold_off = 1'b1;
			end
			repeat (seg) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:   result_stall <= 1'b0;
					STALL_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:  result_stall <= ($urandom_range(0, 3) != 0);
					STALL_TOGGLE: result_stall <= ~result_stall;
					default:      result_stall <= 1'b1;
				endcase
			end
			if (mode == STALL_HOLD) begin
				hold_off  = 1'b0;
				hold_done = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((instr_valid && !instr_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, expected_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIR_ROWS; i++)
			send_instr(dir_tab[i].ins, dir_tab[i].typed, dir_tab[i].want);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_instr(rand_instr(), 1'b0, '0);
		instr_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display({"ran %0d instructions: add %0d, sw %0d, lw %0d (%0d of stored words), ",
			"lui %0d, ori %0d, nop and unused %0d"},
			accepted_n, ops_seen[OP_ADD], ops_seen[OP_SW], ops_seen[OP_LW], lw_hits,
			ops_seen[OP_LUI], ops_seen[OP_ORI],
			ops_seen[OP_NOP] + ops_seen[OP_RSVD6] + ops_seen[OP_RSVD7]);
		$display("checked %0d result beats, %0d writes to r0 dropped, %0d mismatches",
			checked_n, r0_drops, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== mips_subset_execute.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_front.sv
hw/rtl/mse_back.sv
hw/rtl/mips_subset_execute.sv
bench/mips_subset_execute_tb.sv
